FILE: design/cubic_bezier_path_flattener_macros.svh
// Assertion helpers for the path flattener. Both expect clk and rst in scope.
`ifndef CUBIC_BEZIER_PATH_FLATTENER_MACROS_SVH
`define CUBIC_BEZIER_PATH_FLATTENER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CBPF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CBPF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/cbpf_pkg.sv
package cbpf_pkg;

  localparam int COORD_BITS       = 24;
  localparam int MAX_SUBDIVISIONS = 64;
  localparam int SUBDIV_BITS      = 7;
  localparam int SUBDIV_RESET     = 8;
  localparam int STEP_BITS        = $clog2(MAX_SUBDIVISIONS);
  // Divisor of the t increment is twice the subdivision count.
  localparam int DIVR_BITS        = $clog2(2 * MAX_SUBDIVISIONS) + 1;
  localparam int T_FRAC           = 16;
  localparam int T_BITS           = T_FRAC + 1;
  localparam int DIV_LAST         = T_BITS;
  localparam int DIV_CNT_BITS     = $clog2(DIV_LAST + 1);
  localparam int W_FRAC           = 24;
  localparam int W_BITS           = W_FRAC + 2;
  localparam int UU_BITS          = 2 * T_BITS;
  localparam int MUL_A_BITS       = UU_BITS + 1;
  localparam int MUL_B_BITS       = W_BITS;
  localparam int PROD_BITS        = MUL_A_BITS + MUL_B_BITS;
  localparam int ACC_BITS         = W_BITS + COORD_BITS + 2;
  localparam int IN_DATA_BITS     = ((6 * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS    = ((2 * COORD_BITS + 7) / 8) * 8;
  localparam int CMAX             = (1 << (COORD_BITS - 1)) - 1;
  localparam int CMIN             = -CMAX - 1;

  localparam logic [T_BITS:0]             T_ONE    = (T_BITS + 1)'(1 << T_FRAC);
  localparam logic signed [W_BITS-1:0]    W_ONE    = W_BITS'(1 << W_FRAC);
  localparam logic [ACC_BITS-1:0]         W_HALF   = ACC_BITS'(1) << (W_FRAC - 1);
  localparam logic signed [ACC_BITS-1:0]  ACC_HALF = ACC_BITS'(1) << (W_FRAC - 1);
  localparam logic signed [ACC_BITS-1:0]  ACC_CMAX = ACC_BITS'(CMAX);
  localparam logic signed [ACC_BITS-1:0]  ACC_CMIN = ACC_BITS'(CMIN);
  localparam logic [1:0]                  PTS_MAX  = 2'd3;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef enum logic [1:0] {
    MODE_MOVE  = 2'd0,
    MODE_LINE  = 2'd1,
    MODE_CUBIC = 2'd2,
    MODE_CLOSE = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STATUS_POINT   = 2'd0,
    STATUS_PATH_OK = 2'd1,
    STATUS_TOO_FEW = 2'd2,
    STATUS_BAD_SEQ = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_STEP,
    ST_CALC,
    ST_POINT,
    ST_END
  } state_t;

  // Multiplier slots of one interior point, issued in this order.
  typedef enum logic [3:0] {
    OP_UU,
    OP_UT,
    OP_W0,
    OP_W1,
    OP_W2,
    OP_BX0,
    OP_BX1,
    OP_BX2,
    OP_BX3,
    OP_BY0,
    OP_BY1,
    OP_BY2,
    OP_BY3,
    OP_DONE
  } op_t;

  function automatic coord_t clamp_coord(input logic signed [ACC_BITS-1:0] v);
    coord_t r;
    if (v > ACC_CMAX) begin
      r = COORD_BITS'(CMAX);
    end else if (v < ACC_CMIN) begin
      r = COORD_BITS'(CMIN);
    end else begin
      r = v[COORD_BITS-1:0];
    end
    return r;
  endfunction

endpackage

FILE: design/cubic_bezier_path_flattener.sv
// Channel   Direction  Beat contents
// s_axis    in         tuser: mode; tdata: end_x, end_y, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y
// m_axis    out        tuser: status; tdata: point_x, point_y; tlast: last
// cfg       in         cfg_data: subdivisions (0 is stored as 1, above 64 as 64)
//
// Move, line and close are answered from the idle state. A cubic with n subdivisions first
// runs a bit-serial divider for the t increment, then for each of its n - 1 interior points
// issues the weight and blend products on the one shared 35x26 multiplier. Reset is
// synchronous and clears the path state with no clearing pass. A stalled m_axis holds the
// block once it has a result to emit; the next command is accepted only while the output
// register is empty or its result is being taken.
`include "cubic_bezier_path_flattener_macros.svh"

module cubic_bezier_path_flattener (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // mode
  input  logic [1:0]                            s_axis_tuser,
  // end_x, end_y, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y
  input  logic [cbpf_pkg::IN_DATA_BITS-1:0]     s_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // status
  output logic [1:0]                            m_axis_tuser,
  // point_x, point_y
  output logic [cbpf_pkg::OUT_DATA_BITS-1:0]    m_axis_tdata,
  output logic                                  m_axis_tlast,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [cbpf_pkg::SUBDIV_BITS-1:0]      cfg_data
);

  cbpf_pkg::state_t  state, state_next;
  cbpf_pkg::op_t     op, op_prev;

  logic [cbpf_pkg::SUBDIV_BITS-1:0]   subdivisions;
  logic                               in_path;
  logic [1:0]                         points_seen;
  cbpf_pkg::coord_t                   current_x, current_y;

  cbpf_pkg::coord_t                   end_x, end_y, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y;
  cbpf_pkg::coord_t                   in_end_x, in_end_y;
  cbpf_pkg::mode_t                    in_mode;
  logic                               in_fire, out_free, bad_seq;

  // t increment divider
  logic [cbpf_pkg::DIV_CNT_BITS-1:0]  dcnt;
  logic [cbpf_pkg::DIVR_BITS-1:0]     drem;
  logic [cbpf_pkg::T_BITS-1:0]        quo;
  logic [cbpf_pkg::DIVR_BITS-1:0]     div_d;
  logic [cbpf_pkg::DIVR_BITS:0]       div_trial;
  logic                               div_ge;

  // Per-point parameter
  logic [cbpf_pkg::STEP_BITS-1:0]     step;
  logic [cbpf_pkg::T_BITS-1:0]        t, u, t_next;
  logic [cbpf_pkg::DIVR_BITS-1:0]     rem, rem_next;
  logic [cbpf_pkg::DIVR_BITS:0]       step_sum;
  logic                               step_carry;
  logic                               last_interior;

  // Shared multiplier and its results
  logic signed [cbpf_pkg::MUL_A_BITS-1:0] mul_a;
  logic signed [cbpf_pkg::MUL_B_BITS-1:0] mul_b;
  logic signed [cbpf_pkg::PROD_BITS-1:0]  prod;
  logic [cbpf_pkg::ACC_BITS-1:0]          prod_u, prod_3, wr_1, wr_3;
  logic [cbpf_pkg::UU_BITS-1:0]           uu, ut;
  logic signed [cbpf_pkg::W_BITS-1:0]     w0, w1, w2, w3;
  logic signed [cbpf_pkg::ACC_BITS-1:0]   acc_x, acc_y, prod_s, rnd_x, rnd_y;

  // Output register
  logic                               out_load;
  cbpf_pkg::coord_t                   out_x, out_y, out_x_next, out_y_next;
  cbpf_pkg::status_t                  out_status, out_status_next;
  logic                               out_last, out_last_next;

  assign in_mode  = cbpf_pkg::mode_t'(s_axis_tuser);
  assign in_end_x = s_axis_tdata[0 * cbpf_pkg::COORD_BITS +: cbpf_pkg::COORD_BITS];
  assign in_end_y = s_axis_tdata[1 * cbpf_pkg::COORD_BITS +: cbpf_pkg::COORD_BITS];
  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign bad_seq  = (in_mode == cbpf_pkg::MODE_MOVE) == in_path;

  assign cfg_ready     = 1'b1;
  assign m_axis_tdata  = cbpf_pkg::OUT_DATA_BITS'({out_y, out_x});
  assign m_axis_tuser  = out_status;
  assign m_axis_tlast  = out_last;

  // Divider: 2^17 / (2n), one quotient bit a cycle. Only the top dividend bit is set.
  assign div_d     = {subdivisions, 1'b0};
  assign div_trial = {drem, dcnt == '0};
  assign div_ge    = div_trial >= (cbpf_pkg::DIVR_BITS + 1)'(div_d);

  // t advances by the quotient, plus one when the running remainder wraps.
  assign step_sum      = (cbpf_pkg::DIVR_BITS + 1)'(rem) + (cbpf_pkg::DIVR_BITS + 1)'(drem);
  assign step_carry    = step_sum >= (cbpf_pkg::DIVR_BITS + 1)'(div_d);
  assign rem_next      = step_carry ?
                         cbpf_pkg::DIVR_BITS'(step_sum - (cbpf_pkg::DIVR_BITS + 1)'(div_d)) :
                         step_sum[cbpf_pkg::DIVR_BITS-1:0];
  assign t_next        = t + quo + cbpf_pkg::T_BITS'(step_carry);
  assign last_interior = (cbpf_pkg::SUBDIV_BITS'(step) + cbpf_pkg::SUBDIV_BITS'(1))
                         == subdivisions;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (op)
      cbpf_pkg::OP_UU: begin
        mul_a = $signed(cbpf_pkg::MUL_A_BITS'(u));
        mul_b = $signed(cbpf_pkg::MUL_B_BITS'(u));
      end
      cbpf_pkg::OP_UT: begin
        mul_a = $signed(cbpf_pkg::MUL_A_BITS'(u));
        mul_b = $signed(cbpf_pkg::MUL_B_BITS'(t));
      end
      cbpf_pkg::OP_W0: begin
        mul_a = $signed(cbpf_pkg::MUL_A_BITS'(uu));
        mul_b = $signed(cbpf_pkg::MUL_B_BITS'(u));
      end
      cbpf_pkg::OP_W1: begin
        mul_a = $signed(cbpf_pkg::MUL_A_BITS'(uu));
        mul_b = $signed(cbpf_pkg::MUL_B_BITS'(t));
      end
      cbpf_pkg::OP_W2: begin
        mul_a = $signed(cbpf_pkg::MUL_A_BITS'(ut));
        mul_b = $signed(cbpf_pkg::MUL_B_BITS'(t));
      end
      cbpf_pkg::OP_BX0: begin
        mul_a = cbpf_pkg::MUL_A_BITS'(current_x);
        mul_b = w0;
      end
      cbpf_pkg::OP_BX1: begin
        mul_a = cbpf_pkg::MUL_A_BITS'(ctrl1_x);
        mul_b = w1;
      end
      cbpf_pkg::OP_BX2: begin
        mul_a = cbpf_pkg::MUL_A_BITS'(ctrl2_x);
        mul_b = w2;
      end
      cbpf_pkg::OP_BX3: begin
        mul_a = cbpf_pkg::MUL_A_BITS'(end_x);
        mul_b = w3;
      end
      cbpf_pkg::OP_BY0: begin
        mul_a = cbpf_pkg::MUL_A_BITS'(current_y);
        mul_b = w0;
      end
      cbpf_pkg::OP_BY1: begin
        mul_a = cbpf_pkg::MUL_A_BITS'(ctrl1_y);
        mul_b = w1;
      end
      cbpf_pkg::OP_BY2: begin
        mul_a = cbpf_pkg::MUL_A_BITS'(ctrl2_y);
        mul_b = w2;
      end
      cbpf_pkg::OP_BY3: begin
        mul_a = cbpf_pkg::MUL_A_BITS'(end_y);
        mul_b = w3;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Weight products are never negative; the middle two weights carry the factor three.
  assign prod_u = prod[cbpf_pkg::ACC_BITS-1:0];
  assign prod_3 = prod_u + (prod_u << 1);
  assign wr_1   = prod_u + cbpf_pkg::W_HALF;
  assign wr_3   = prod_3 + cbpf_pkg::W_HALF;
  assign prod_s = $signed(prod[cbpf_pkg::ACC_BITS-1:0]);
  assign rnd_x  = (acc_x + cbpf_pkg::ACC_HALF) >>> cbpf_pkg::W_FRAC;
  assign rnd_y  = (acc_y + cbpf_pkg::ACC_HALF) >>> cbpf_pkg::W_FRAC;

  always_comb begin
    state_next      = state;
    s_axis_tready   = 1'b0;
    out_load        = 1'b0;
    out_x_next      = '0;
    out_y_next      = '0;
    out_status_next = cbpf_pkg::STATUS_POINT;
    out_last_next   = 1'b0;
    case (state)
      cbpf_pkg::ST_IDLE: begin
        s_axis_tready = out_free;
        if (s_axis_tvalid && out_free) begin
          if (bad_seq) begin
            out_load        = 1'b1;
            out_status_next = cbpf_pkg::STATUS_BAD_SEQ;
            out_last_next   = 1'b1;
          end else begin
            case (in_mode)
              cbpf_pkg::MODE_MOVE, cbpf_pkg::MODE_LINE: begin
                out_load      = 1'b1;
                out_x_next    = in_end_x;
                out_y_next    = in_end_y;
                out_last_next = 1'b1;
              end
              cbpf_pkg::MODE_CUBIC: begin
                state_next = cbpf_pkg::ST_DIV;
              end
              default: begin
                out_load        = 1'b1;
                out_status_next = (points_seen == cbpf_pkg::PTS_MAX) ?
                                  cbpf_pkg::STATUS_PATH_OK : cbpf_pkg::STATUS_TOO_FEW;
                out_last_next   = 1'b1;
              end
            endcase
          end
        end
      end
      cbpf_pkg::ST_DIV: begin
        if (dcnt == cbpf_pkg::DIV_CNT_BITS'(cbpf_pkg::DIV_LAST)) begin
          state_next = (subdivisions == cbpf_pkg::SUBDIV_BITS'(1)) ?
                       cbpf_pkg::ST_END : cbpf_pkg::ST_STEP;
        end
      end
      cbpf_pkg::ST_STEP: begin
        state_next = cbpf_pkg::ST_CALC;
      end
      cbpf_pkg::ST_CALC: begin
        if (op_prev == cbpf_pkg::OP_BY3) begin
          state_next = cbpf_pkg::ST_POINT;
        end
      end
      cbpf_pkg::ST_POINT: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_x_next = cbpf_pkg::clamp_coord(rnd_x);
          out_y_next = cbpf_pkg::clamp_coord(rnd_y);
          state_next = last_interior ? cbpf_pkg::ST_END : cbpf_pkg::ST_STEP;
        end
      end
      cbpf_pkg::ST_END: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_x_next    = end_x;
          out_y_next    = end_y;
          out_last_next = 1'b1;
          state_next    = cbpf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = cbpf_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cbpf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  logic [cbpf_pkg::SUBDIV_BITS:0] pts_sum;
  assign pts_sum = (cbpf_pkg::SUBDIV_BITS + 1)'(points_seen)
                   + (cbpf_pkg::SUBDIV_BITS + 1)'(subdivisions);

  // Path state, configuration and output handshake.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      subdivisions  <= cbpf_pkg::SUBDIV_BITS'(cbpf_pkg::SUBDIV_RESET);
      in_path       <= 1'b0;
      points_seen   <= '0;
      current_x     <= '0;
      current_y     <= '0;
    end else begin
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end

      if (cfg_valid && cfg_ready) begin
        if (cfg_data == '0) begin
          subdivisions <= cbpf_pkg::SUBDIV_BITS'(1);
        end else if (cfg_data > cbpf_pkg::SUBDIV_BITS'(cbpf_pkg::MAX_SUBDIVISIONS)) begin
          subdivisions <= cbpf_pkg::SUBDIV_BITS'(cbpf_pkg::MAX_SUBDIVISIONS);
        end else begin
          subdivisions <= cfg_data;
        end
      end

      if (in_fire) begin
        if (bad_seq) begin
          in_path     <= 1'b0;
          points_seen <= '0;
        end else begin
          case (in_mode)
            cbpf_pkg::MODE_MOVE: begin
              in_path     <= 1'b1;
              points_seen <= 2'd1;
              current_x   <= in_end_x;
              current_y   <= in_end_y;
            end
            cbpf_pkg::MODE_LINE: begin
              points_seen <= (points_seen == cbpf_pkg::PTS_MAX) ?
                             cbpf_pkg::PTS_MAX : points_seen + 2'd1;
              current_x   <= in_end_x;
              current_y   <= in_end_y;
            end
            cbpf_pkg::MODE_CUBIC: begin
              in_path <= in_path;
            end
            default: begin
              in_path     <= 1'b0;
              points_seen <= '0;
            end
          endcase
        end
      end

      if (state == cbpf_pkg::ST_END && out_free) begin
        current_x   <= end_x;
        current_y   <= end_y;
        points_seen <= (pts_sum >= (cbpf_pkg::SUBDIV_BITS + 1)'(cbpf_pkg::PTS_MAX)) ?
                       cbpf_pkg::PTS_MAX : pts_sum[1:0];
      end
    end
  end

  // Sequencer datapath: divider, parameter step, shared multiplier and accumulators.
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;

    if (out_load) begin
      out_x      <= out_x_next;
      out_y      <= out_y_next;
      out_status <= out_status_next;
      out_last   <= out_last_next;
    end

    case (state)
      cbpf_pkg::ST_IDLE: begin
        if (in_fire) begin
          end_x   <= in_end_x;
          end_y   <= in_end_y;
          ctrl1_x <= s_axis_tdata[2 * cbpf_pkg::COORD_BITS +: cbpf_pkg::COORD_BITS];
          ctrl1_y <= s_axis_tdata[3 * cbpf_pkg::COORD_BITS +: cbpf_pkg::COORD_BITS];
          ctrl2_x <= s_axis_tdata[4 * cbpf_pkg::COORD_BITS +: cbpf_pkg::COORD_BITS];
          ctrl2_y <= s_axis_tdata[5 * cbpf_pkg::COORD_BITS +: cbpf_pkg::COORD_BITS];
          dcnt    <= '0;
          drem    <= '0;
          quo     <= '0;
          t       <= '0;
          rem     <= cbpf_pkg::DIVR_BITS'(subdivisions);
          step    <= '0;
        end
      end
      cbpf_pkg::ST_DIV: begin
        dcnt <= dcnt + cbpf_pkg::DIV_CNT_BITS'(1);
        drem <= div_ge ? cbpf_pkg::DIVR_BITS'(div_trial - (cbpf_pkg::DIVR_BITS + 1)'(div_d)) :
                         div_trial[cbpf_pkg::DIVR_BITS-1:0];
        quo  <= {quo[cbpf_pkg::T_BITS-2:0], div_ge};
      end
      cbpf_pkg::ST_STEP: begin
        t       <= t_next;
        u       <= cbpf_pkg::T_BITS'(cbpf_pkg::T_ONE - (cbpf_pkg::T_BITS + 1)'(t_next));
        rem     <= rem_next;
        step    <= step + cbpf_pkg::STEP_BITS'(1);
        op      <= cbpf_pkg::OP_UU;
        op_prev <= cbpf_pkg::OP_DONE;
      end
      cbpf_pkg::ST_CALC: begin
        op_prev <= op;
        if (op != cbpf_pkg::OP_DONE) begin
          op <= cbpf_pkg::op_t'(op + 4'd1);
        end
        // The product of the previous slot is in prod now.
        case (op_prev)
          cbpf_pkg::OP_UU:  uu <= prod_u[cbpf_pkg::UU_BITS-1:0];
          cbpf_pkg::OP_UT:  ut <= prod_u[cbpf_pkg::UU_BITS-1:0];
          cbpf_pkg::OP_W0:  w0 <= $signed(cbpf_pkg::W_BITS'(wr_1 >> cbpf_pkg::W_FRAC));
          cbpf_pkg::OP_W1:  w1 <= $signed(cbpf_pkg::W_BITS'(wr_3 >> cbpf_pkg::W_FRAC));
          cbpf_pkg::OP_W2:  w2 <= $signed(cbpf_pkg::W_BITS'(wr_3 >> cbpf_pkg::W_FRAC));
          cbpf_pkg::OP_BX0: begin
            acc_x <= prod_s;
            w3    <= cbpf_pkg::W_ONE - w0 - w1 - w2;
          end
          cbpf_pkg::OP_BX1, cbpf_pkg::OP_BX2, cbpf_pkg::OP_BX3: acc_x <= acc_x + prod_s;
          cbpf_pkg::OP_BY0: acc_y <= prod_s;
          cbpf_pkg::OP_BY1, cbpf_pkg::OP_BY2, cbpf_pkg::OP_BY3: acc_y <= acc_y + prod_s;
          default: acc_y <= acc_y;
        endcase
      end
      default: begin
        dcnt <= dcnt;
      end
    endcase
  end

  `CBPF_ASSERT_NOW(a_no_points_outside_path, !in_path, points_seen == 2'd0, "points outside a path")
  `CBPF_ASSERT_NOW(a_subdiv_in_range, 1'b1, subdivisions != '0 && subdivisions <= cbpf_pkg::SUBDIV_BITS'(cbpf_pkg::MAX_SUBDIVISIONS), "subdivisions out of range")
  `CBPF_ASSERT_NOW(a_rem_below_divisor, state == cbpf_pkg::ST_CALC, rem < div_d, "t remainder not reduced")
  `CBPF_ASSERT_NEXT(a_cubic_starts_divider, in_fire && in_mode == cbpf_pkg::MODE_CUBIC && !bad_seq, state == cbpf_pkg::ST_DIV, "cubic did not start the divider")
  `CBPF_ASSERT_NOW(a_interior_step_bound, state == cbpf_pkg::ST_POINT, cbpf_pkg::SUBDIV_BITS'(step) < subdivisions, "interior step past subdivisions")

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import cbpf_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 1000000;
  localparam int unsigned SETTLE_CYCLES = 20;
  localparam int unsigned PHASE_ITEMS   = 14;
  localparam int unsigned PHASE_COUNT   = 7;
  localparam coord_t      XMAX          = coord_t'(CMAX);
  localparam coord_t      XMIN          = coord_t'(CMIN);

  typedef struct packed {
    mode_t  mode;
    coord_t end_x;
    coord_t end_y;
    coord_t ctrl1_x;
    coord_t ctrl1_y;
    coord_t ctrl2_x;
    coord_t ctrl2_y;
  } path_command_t;

  typedef struct packed {
    coord_t  x;
    coord_t  y;
    status_t status;
    logic    is_last;
  } vertex_beat_t;

  // Tracks the path state of the flattener and keeps the output beats it should produce.
  class vertex_checker;
    vertex_beat_t expected_beats[$];
    int unsigned  errors;
    int unsigned  subdivisions;
    coord_t       cur_x;
    coord_t       cur_y;
    bit           in_path;
    int unsigned  points_in_path;

    function new();
      errors         = 0;
      subdivisions   = SUBDIV_RESET;
      cur_x          = '0;
      cur_y          = '0;
      in_path        = 1'b0;
      points_in_path = 0;
    endfunction

    function void write_subdivisions(input logic [SUBDIV_BITS-1:0] value);
      if (value == 0) begin
        subdivisions = 1;
      end else if (value > MAX_SUBDIVISIONS) begin
        subdivisions = MAX_SUBDIVISIONS;
      end else begin
        subdivisions = value;
      end
    endfunction

    function int unsigned pending();
      return expected_beats.size();
    endfunction

    function void push_beat(input coord_t x, input coord_t y, input status_t status,
                            input logic is_last);
      vertex_beat_t b;
      b.x       = x;
      b.y       = y;
      b.status  = status;
      b.is_last = is_last;
      expected_beats.push_back(b);
    endfunction

    // Weights are Q0.24; adding half before the arithmetic shift rounds halves upward.
    function coord_t blend(input longint w0, input longint w1, input longint w2,
                           input longint w3, input longint p0, input longint p1,
                           input longint p2, input longint p3);
      longint acc;
      acc = w0 * p0 + w1 * p1 + w2 * p2 + w3 * p3 + (64'sd1 <<< 23);
      acc = acc >>> 24;
      if (acc > CMAX) begin
        acc = CMAX;
      end else if (acc < CMIN) begin
        acc = CMIN;
      end
      return coord_t'(acc);
    endfunction

    function void accept_command(input path_command_t cmd);
      longint unsigned t;
      longint unsigned u;
      longint          w0;
      longint          w1;
      longint          w2;
      longint          w3;
      int unsigned     s;
      if ((cmd.mode == MODE_MOVE) == in_path) begin
        in_path        = 1'b0;
        points_in_path = 0;
        push_beat('0, '0, STATUS_BAD_SEQ, 1'b1);
      end else if (cmd.mode == MODE_MOVE || cmd.mode == MODE_LINE) begin
        if (cmd.mode == MODE_MOVE) begin
          in_path        = 1'b1;
          points_in_path = 0;
        end
        points_in_path = (points_in_path + 1 >= 3) ? 3 : points_in_path + 1;
        cur_x          = cmd.end_x;
        cur_y          = cmd.end_y;
        push_beat(cmd.end_x, cmd.end_y, STATUS_POINT, 1'b1);
      end else if (cmd.mode == MODE_CUBIC) begin
        for (s = 1; s < subdivisions; s++) begin
          t  = (64'(s) * 64'd131072 + 64'(subdivisions)) / (64'd2 * 64'(subdivisions));
          u  = 64'd65536 - t;
          w0 = longint'((u * u * u + 64'd8388608) >> 24);
          w1 = longint'((64'd3 * u * u * t + 64'd8388608) >> 24);
          w2 = longint'((64'd3 * u * t * t + 64'd8388608) >> 24);
          w3 = 64'sd16777216 - w0 - w1 - w2;
          push_beat(blend(w0, w1, w2, w3, longint'(cur_x), longint'(cmd.ctrl1_x),
                          longint'(cmd.ctrl2_x), longint'(cmd.end_x)),
                    blend(w0, w1, w2, w3, longint'(cur_y), longint'(cmd.ctrl1_y),
                          longint'(cmd.ctrl2_y), longint'(cmd.end_y)),
                    STATUS_POINT, 1'b0);
        end
        // The final sample lands on the end point exactly.
        push_beat(cmd.end_x, cmd.end_y, STATUS_POINT, 1'b1);
        points_in_path = (points_in_path + subdivisions >= 3) ? 3
                                                              : points_in_path + subdivisions;
        cur_x          = cmd.end_x;
        cur_y          = cmd.end_y;
      end else begin
        push_beat('0, '0, (points_in_path >= 3) ? STATUS_PATH_OK : STATUS_TOO_FEW, 1'b1);
        in_path        = 1'b0;
        points_in_path = 0;
      end
    endfunction

    function void check_vertex(input coord_t x, input coord_t y, input logic [1:0] status,
                               input logic is_last);
      vertex_beat_t want;
      if (expected_beats.size() == 0) begin
        $error("unexpected result beat: point_x %0d point_y %0d status %0d last %0d",
               x, y, status, is_last);
        errors++;
      end else begin
        want = expected_beats.pop_front();
        if (x !== want.x) begin
          $error("point_x: expected %0d, actual %0d", want.x, x);
          errors++;
        end
        if (y !== want.y) begin
          $error("point_y: expected %0d, actual %0d", want.y, y);
          errors++;
        end
        if (status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, status);
          errors++;
        end
        if (is_last !== want.is_last) begin
          $error("last: expected %0d, actual %0d", want.is_last, is_last);
          errors++;
        end
      end
    endfunction
  endclass

  logic                     clk             = 1'b0;
  logic                     rst             = 1'b1;
  logic                     s_axis_tvalid   = 1'b0;
  logic                     s_axis_tready;
  logic [1:0]               s_axis_tuser    = '0;
  logic [IN_DATA_BITS-1:0]  s_axis_tdata    = '0;
  logic                     m_axis_tvalid;
  logic                     m_axis_tready   = 1'b0;
  logic [1:0]               m_axis_tuser;
  logic [OUT_DATA_BITS-1:0] m_axis_tdata;
  logic                     m_axis_tlast;
  logic                     cfg_valid       = 1'b0;
  logic                     cfg_ready;
  logic [SUBDIV_BITS-1:0]   cfg_data        = '0;

  bit                       no_gaps         = 1'b0;
  int unsigned              hold_off_cycles = 0;
  int unsigned              commands_sent   = 0;
  vertex_checker            board           = new();

  cubic_bezier_path_flattener dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 9))
      0: return XMIN;
      1: return XMAX;
      2: return '0;
      default: return coord_t'($urandom());
    endcase
  endfunction

  function automatic path_command_t command_of(input mode_t m, input coord_t ex,
                                               input coord_t ey, input coord_t c1x,
                                               input coord_t c1y, input coord_t c2x,
                                               input coord_t c2y);
    path_command_t cmd;
    cmd.mode    = m;
    cmd.end_x   = ex;
    cmd.end_y   = ey;
    cmd.ctrl1_x = c1x;
    cmd.ctrl1_y = c1y;
    cmd.ctrl2_x = c2x;
    cmd.ctrl2_y = c2y;
    return cmd;
  endfunction

  function automatic path_command_t random_command(input mode_t m);
    return command_of(m, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                      rand_coord(), rand_coord());
  endfunction

  // Leaves tvalid high on return so that a back-to-back beat needs no second assignment.
  task automatic send_command(input path_command_t cmd);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd.mode;
    s_axis_tdata  <= {cmd.ctrl2_y, cmd.ctrl2_x, cmd.ctrl1_y, cmd.ctrl1_x,
                      cmd.end_y, cmd.end_x};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    board.accept_command(cmd);
    commands_sent++;
  endtask

  task automatic send_random_path();
    int unsigned kind;
    int unsigned segments;
    int unsigned i;
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      send_command(random_command(mode_t'($urandom_range(0, 3))));
    end else begin
      send_command(random_command(MODE_MOVE));
      segments = $urandom_range(0, 4);
      for (i = 0; i < segments; i++) begin
        send_command(random_command(($urandom_range(0, 4) < 2) ? MODE_CUBIC : MODE_LINE));
      end
      // Now and then a path is left open so the next move lands mid-path.
      if (kind != 1) begin
        send_command(random_command(MODE_CLOSE));
      end
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (board.pending() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_subdivisions(input logic [SUBDIV_BITS-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    board.write_subdivisions(value);
  endtask

  initial begin : result_sink
    int unsigned gap;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      gap = no_gaps ? 0 : $urandom_range(0, 10);
      if (hold_off_cycles > 0) begin
        gap             = hold_off_cycles;
        hold_off_cycles = 0;
      end
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
      board.check_vertex(coord_t'(m_axis_tdata[COORD_BITS-1:0]),
                         coord_t'(m_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
                         m_axis_tuser, m_axis_tlast);
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("cubic_bezier_path_flattener test failed");
    $finish;
  end

  initial begin : stimulus
    logic [SUBDIV_BITS-1:0] setting;
    int unsigned            phase;
    int unsigned            first;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at the reset setting of eight points per cubic.
    send_command(command_of(MODE_CLOSE, 0, 0, 0, 0, 0, 0));
    send_command(command_of(MODE_LINE, 100, 200, 0, 0, 0, 0));
    send_command(command_of(MODE_CUBIC, 5, 6, 7, 8, 9, 10));
    send_command(command_of(MODE_MOVE, XMIN, XMAX, XMAX, XMIN, XMAX, XMIN));
    send_command(command_of(MODE_MOVE, XMAX, XMIN, 0, 0, 0, 0));
    send_command(command_of(MODE_MOVE, XMAX, XMIN, -1, -1, -1, -1));
    send_command(command_of(MODE_CLOSE, XMAX, XMAX, XMAX, XMAX, XMAX, XMAX));
    send_command(command_of(MODE_MOVE, 0, 0, 0, 0, 0, 0));
    send_command(command_of(MODE_LINE, XMAX, XMAX, 0, 0, 0, 0));
    send_command(command_of(MODE_CLOSE, 0, 0, 0, 0, 0, 0));
    send_command(command_of(MODE_MOVE, -256, 256, 0, 0, 0, 0));
    send_command(command_of(MODE_LINE, 256, 256, 0, 0, 0, 0));
    send_command(command_of(MODE_LINE, 0, -256, 0, 0, 0, 0));
    send_command(command_of(MODE_CLOSE, 0, 0, 0, 0, 0, 0));
    send_command(command_of(MODE_MOVE, XMIN, XMIN, 0, 0, 0, 0));
    send_command(command_of(MODE_CUBIC, XMAX, XMAX, XMAX, XMIN, XMIN, XMAX));
    send_command(command_of(MODE_CLOSE, 0, 0, 0, 0, 0, 0));
    send_command(command_of(MODE_MOVE, 0, 0, 0, 0, 0, 0));
    send_command(command_of(MODE_CUBIC, -1, -1, XMIN, XMIN, XMAX, XMAX));
    send_command(command_of(MODE_LINE, XMIN, XMAX, 0, 0, 0, 0));
    send_command(command_of(MODE_CUBIC, 1, 0, 0, XMAX, XMAX, XMIN));
    send_command(command_of(MODE_CLOSE, 0, 0, 0, 0, 0, 0));
    send_command(command_of(MODE_MOVE, 512, -512, 0, 0, 0, 0));
    send_command(command_of(MODE_MOVE, 1, 1, 0, 0, 0, 0));
    send_command(command_of(MODE_CUBIC, 300, 300, 100, 200, 200, 100));
    drain();

    for (phase = 0; phase < PHASE_COUNT; phase++) begin
      case (phase)
        0: setting = '0;
        1: setting = 7'd64;
        2: setting = 7'd127;
        3: setting = 7'd1;
        4: setting = SUBDIV_BITS'($urandom_range(2, 63));
        5: setting = SUBDIV_BITS'($urandom_range(0, 127));
        default: setting = 7'd3;
      endcase
      program_subdivisions(setting);
      no_gaps = (phase % 3 == 2);
      // A long receiver stall with long cubics backs the block up into its input.
      if (phase == 1) begin
        hold_off_cycles = 400;
      end
      first = commands_sent;
      while (commands_sent - first < PHASE_ITEMS) send_random_path();
      drain();
    end

    if (board.errors == 0) begin
      $display("cubic_bezier_path_flattener test passed");
    end else begin
      $display("cubic_bezier_path_flattener test failed");
    end
    $finish;
  end

endmodule
